@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is held.
`define ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Concurrent assertion that is also checked while reset is held.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ rtl/rlfm_pkg.sv @@
// Package with the constants, types and helper functions of the light falloff mask.
`default_nettype none

package rlfm_pkg;

    // Configuration port geometry.
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_CENTER_X   = 2'd0;
    localparam logic [1:0] REG_CENTER_Y   = 2'd1;
    localparam logic [1:0] REG_BASE_RANGE = 2'd2;

    // Screen geometry, used for the reset position of the centre.
    localparam int unsigned SCREEN_WIDTH  = 160;
    localparam int unsigned SCREEN_HEIGHT = 120;

    localparam logic [7:0]  CENTER_X_RESET   = 8'((SCREEN_WIDTH / 2) % 256);
    localparam logic [7:0]  CENTER_Y_RESET   = 8'((SCREEN_HEIGHT / 2) % 256);
    localparam logic [7:0]  BASE_RANGE_RESET = 8'd46;
    localparam logic [31:0] PRNG_SEED        = 32'h0000_1337;
    localparam logic [15:0] RANGE_RESET      = 16'd10240;

    localparam logic [5:0]  LEVEL_FULL = 6'd32;

    // Pixel held between the input register and the result register.
    typedef struct packed {
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic [7:0] radius;
        logic [1:0] dither;
    } pix_stage_t;

    // One step of the 32-bit xorshift generator with shifts 13, 17 and 5.
    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    // Moves the smoothed radius one eighth of the way toward the target,
    // rounding towards minus infinity in both directions.
    function automatic logic [15:0] range_step(input logic [15:0] range_cur,
                                               input logic [7:0]  base,
                                               input logic [11:0] draw);
        logic [16:0] target;
        logic [15:0] target_sat;
        logic [16:0] diff;
        logic [15:0] result;
        target     = {1'b0, base, 8'd0} + {5'd0, draw};
        target_sat = target[16] ? 16'hFFFF : target[15:0];
        if (target_sat >= range_cur) begin
            diff   = {1'b0, target_sat} - {1'b0, range_cur};
            result = range_cur + 16'(diff >> 3);
        end else begin
            diff   = {1'b0, range_cur} - {1'b0, target_sat} + 17'd7;
            result = range_cur - 16'(diff >> 3);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

@@ rtl/radial_light_falloff_mask_core.sv @@
// Top level of the radial light falloff mask with flickering radius and dither.
//
// Usage: pixel coordinates enter on the s_ stream, one item per pixel, with
// s_tuser[0] raised on the first pixel of each frame. Each accepted item yields
// exactly one result item on the m_ stream: m_tuser[0] is the darken flag and
// m_tdata[5:0] the falloff factor out of 32 (32 whenever darken is low).
// The lit centre and the base radius are set through the APB-style port at
// byte addresses 0, 4 and 8; they should only be changed while no item is in
// flight.
// The result passes through the input register and then the result register
// before it is shown on m_. One item is accepted every cycle while the
// receiver keeps m_tready high; the generator and radius update both complete
// within the acceptance cycle of their item, so nothing else limits the rate.
// A synchronous reset (aresetn low) empties both stages, restores the register
// defaults and reseeds the generator and the smoothed radius.
// When the receiver holds m_tready low the result stays on the port; an empty
// input register still takes one more item, after which s_tready drops
// until the result is taken.
`default_nettype none

module radial_light_falloff_mask_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [15:0]                    s_tdata,   // [7:0] pixel_x, [15:8] pixel_y
    input  wire logic [0:0]                     s_tuser,   // [0] frame_start
    // Result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [7:0]                          m_tdata,   // [5:0] light_level, [7:6] zero
    output logic [0:0]                          m_tuser,   // [0] darken
    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rlfm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [rlfm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rlfm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import rlfm_pkg::*;

    // Configuration registers.
    logic [7:0]  center_x_reg;
    logic [7:0]  center_y_reg;
    logic [7:0]  base_range_reg;

    // Generator and smoothed radius (8.8 fixed point).
    logic [31:0] prng_reg;
    logic [15:0] range_reg;
    logic [31:0] prng_next;
    logic [15:0] range_next;
    logic [31:0] prng_once;
    logic [31:0] prng_twice;
    logic [1:0]  dither;

    // Input register and result register.
    pix_stage_t  pix_reg;
    logic        pix_valid_reg;
    logic        out_valid_reg;
    logic        darken_reg;
    logic [5:0]  level_reg;
    logic        darken_next;
    logic [5:0]  level_next;

    logic        out_ready;
    logic        pix_ready;
    logic        in_fire;
    logic        cfg_write;

    // Distance datapath.
    logic [7:0]  dx;
    logic [7:0]  dy;
    logic [7:0]  cheb;
    logic [8:0]  dsum;
    logic [12:0] weighted;
    logic [9:0]  dith_dist;
    logic [9:0]  excess;
    logic [19:0] excess_sq;
    logic [13:0] quad;

    // An output register that is empty or being emptied can take the next
    // result; the input register can then move on as well.
    assign out_ready = !out_valid_reg || m_tready;
    assign pix_ready = !pix_valid_reg || out_ready;
    assign s_tready  = pix_ready;
    assign in_fire   = s_tvalid && pix_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg   <= CENTER_X_RESET;
            center_y_reg   <= CENTER_Y_RESET;
            base_range_reg <= BASE_RANGE_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_CENTER_X:   center_x_reg   <= pwdata[7:0];
                REG_CENTER_Y:   center_y_reg   <= pwdata[7:0];
                REG_BASE_RANGE: base_range_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CENTER_X:   prdata = {24'd0, center_x_reg};
            REG_CENTER_Y:   prdata = {24'd0, center_y_reg};
            REG_BASE_RANGE: prdata = {24'd0, base_range_reg};
            default:        prdata = '0;
        endcase
    end

    // On a frame start the 12-bit radius draw comes first, then the pixel's
    // own 2-bit dither draw, so the generator advances twice in that cycle.
    always_comb begin
        prng_once  = xorshift32(prng_reg);
        prng_twice = xorshift32(prng_once);
        if (s_tuser[0]) begin
            range_next = range_step(range_reg, base_range_reg, prng_once[31:20]);
            prng_next  = prng_twice;
            dither     = prng_twice[31:30];
        end else begin
            range_next = range_reg;
            prng_next  = prng_once;
            dither     = prng_once[31:30];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prng_reg      <= PRNG_SEED;
            range_reg     <= RANGE_RESET;
            pix_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                prng_reg  <= prng_next;
                range_reg <= range_next;
            end
            if (pix_ready) begin
                pix_valid_reg <= s_tvalid;
            end
        end
    end

    // The pixel and its radius snapshot need no reset.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            pix_reg.pixel_x <= s_tdata[7:0];
            pix_reg.pixel_y <= s_tdata[15:8];
            pix_reg.radius  <= range_next[15:8];
            pix_reg.dither  <= dither;
        end
    end

    // Octagonal distance (7*(dx+dy) + 9*max(dx,dy)) / 16 plus the dither,
    // then the quadratic falloff past the radius.
    always_comb begin
        dx = (pix_reg.pixel_x > center_x_reg) ? pix_reg.pixel_x - center_x_reg
                                              : center_x_reg - pix_reg.pixel_x;
        dy = (pix_reg.pixel_y > center_y_reg) ? pix_reg.pixel_y - center_y_reg
                                              : center_y_reg - pix_reg.pixel_y;
        cheb      = (dx > dy) ? dx : dy;
        dsum      = {1'b0, dx} + {1'b0, dy};
        weighted  = 13'(dsum) * 13'd7 + 13'(cheb) * 13'd9;
        dith_dist = {1'b0, weighted[12:4]} + {8'd0, pix_reg.dither};
        excess    = dith_dist - {2'd0, pix_reg.radius};
        excess_sq = excess * excess;
        quad      = excess_sq[19:6];
        if (dith_dist > {2'd0, pix_reg.radius}) begin
            darken_next = 1'b1;
            level_next  = (quad >= 14'd32) ? 6'd0 : LEVEL_FULL - quad[5:0];
        end else begin
            darken_next = 1'b0;
            level_next  = LEVEL_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= pix_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && pix_valid_reg) begin
            darken_reg <= darken_next;
            level_reg  <= level_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'd0, level_reg};
    assign m_tuser  = darken_reg;

endmodule

`default_nettype wire

@@ rtl/rlfm_checker.sv @@
// Port checker for the light falloff mask, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module rlfm_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [0:0] m_tuser
);
    // Reset empties the result stage.
    `ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid)
    // A stalled result stays on the port unchanged.
    `ASSERT_RST(a_stall_holds, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // A lit pixel always carries the full factor.
    `ASSERT_RST(a_lit_full, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata == 8'd32)
    // The factor never exceeds 32.
    `ASSERT_RST(a_level_range, aclk, aresetn, m_tvalid |-> m_tdata <= 8'd32)
    // With no result waiting the block can always take a new item.
    `ASSERT_RST(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready)

endmodule

bind radial_light_falloff_mask_core rlfm_checker u_rlfm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ sim/radial_light_falloff_mask_core_tb.sv @@
// Self-checking testbench for the radial light falloff mask core, with its own flicker predictor.
`default_nettype none

module radial_light_falloff_mask_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlfm_pkg::*;

    // Clock period is 20 ns; the watchdog limit is many times the slowest legal run, even
    // with every stall pattern and hold-off in play.
    localparam int unsigned TIMEOUT_NS    = 10_000_000;
    localparam int unsigned RESET_CYCLES  = 7;
    localparam int unsigned SETTLE_CYCLES = 6;   // margin for the pipeline to settle
    localparam int unsigned HOLDOFF_LEN   = 64;  // long receiver hold-off, in cycles
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_ITEMS   = 180;
    localparam int unsigned DIRECTED_ROWS = 21;
    localparam int unsigned PRINT_CAP     = 40;

    // One result item: the darken flag and the light level out of 32.
    typedef struct packed {
        logic       dk;
        logic [5:0] lvl;
    } falloff_t;

    // One row of the directed stimulus. Where 'typed' is set, 'want' is the result that can
    // be read straight off the geometry; otherwise the predictor supplies the expectation.
    typedef struct packed {
        logic       fs;
        logic [7:0] px;
        logic [7:0] py;
        logic       typed;
        falloff_t   want;
    } pixel_row_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [15:0] s_tdata;   // [7:0] pixel_x, [15:8] pixel_y
    logic [0:0] s_tuser;    // [0] frame_start
    logic m_tvalid;
    logic m_tready;
    logic [7:0] m_tdata;    // [5:0] light_level, [7:6] zero
    logic [0:0] m_tuser;    // [0] darken
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    radial_light_falloff_mask_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Mirror of the block's state and registers; the state is advanced on every accepted item.
    logic [31:0] flicker_state = PRNG_SEED;
    logic [15:0] lit_range     = RANGE_RESET;
    logic [7:0]  centre_x_q    = CENTER_X_RESET;
    logic [7:0]  centre_y_q    = CENTER_Y_RESET;
    logic [7:0]  base_range_q  = BASE_RANGE_RESET;

    // Results still owed by the block, oldest first.
    falloff_t falloff_due [$];

    // Expectation typed into the directed table for the item now on offer.
    logic     row_typed  = 1'b0;
    falloff_t row_expect = '0;

    // Idling controls, written by the stimulus and read by the sender task and the receiver process.
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned holdoff_req     = 0;   // written by the stimulus only

    int unsigned mismatches      = 0;
    int unsigned pixels_accepted = 0;
    int unsigned frame_starts    = 0;
    int unsigned results_checked = 0;
    int unsigned darkened        = 0;

    pixel_row_t dir_rows [DIRECTED_ROWS];
    logic [7:0] phase_cx   [PHASES] = '{8'd80, 8'd0, 8'd255, 8'd128, 8'd200, 8'd40, 8'd0, 8'd0};
    logic [7:0] phase_cy   [PHASES] = '{8'd60, 8'd0, 8'd255, 8'd128, 8'd30, 8'd200, 8'd0, 8'd0};
    logic [7:0] phase_base [PHASES] = '{8'd46, 8'd0, 8'd239, 8'd255, 8'd120, 8'd15, 8'd0, 8'd0};

    // The clock runs freely from time zero.
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // The watchdog ends a run that has hung, whatever the cause.
    initial begin
        #(TIMEOUT_NS);
        $display("[radial_light_falloff_mask_core] ERROR");
        $finish;
    end

    // One line per mismatch, capped so that a broken block cannot flood the log.
    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // 32-bit xorshift step with shifts 13, 17 and 5.
    function automatic logic [31:0] flicker_advance(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        return t ^ (t << 5);
    endfunction

    // Works out the result of one pixel and advances the mirrored state. On a frame start
    // the 12-bit draw for the radius comes first, then the 2-bit dither draw of the pixel.
    function automatic falloff_t predict_falloff(input logic fs, input logic [7:0] px,
                                                 input logic [7:0] py);
        int unsigned target;
        int unsigned dx;
        int unsigned dy;
        int unsigned cheb;
        int unsigned reach;
        int unsigned radius;
        int unsigned over;
        int unsigned q;
        falloff_t r;
        if (fs) begin
            flicker_state = flicker_advance(flicker_state);
            target = 32'(base_range_q) * 256 + 32'(flicker_state[31:20]);
            // A base range above 240 can push the target past 16 bits; it saturates.
            if (target > 32'hFFFF)
                target = 32'hFFFF;
            // The average moves an eighth of the way, rounding down in both directions.
            if (target >= 32'(lit_range))
                lit_range = lit_range + 16'((target - 32'(lit_range)) >> 3);
            else
                lit_range = lit_range - 16'((32'(lit_range) - target + 7) >> 3);
        end
        radius = 32'(lit_range[15:8]);
        dx     = (px > centre_x_q) ? 32'(px - centre_x_q) : 32'(centre_x_q - px);
        dy     = (py > centre_y_q) ? 32'(py - centre_y_q) : 32'(centre_y_q - py);
        cheb   = (dx > dy) ? dx : dy;
        flicker_state = flicker_advance(flicker_state);
        reach  = (((dx + dy) * 7 + cheb * 9) >> 4) + 32'(flicker_state[31:30]);
        r.dk   = 1'b0;
        r.lvl  = LEVEL_FULL;
        if (reach > radius) begin
            over  = reach - radius;
            q     = (over * over) >> 6;
            r.dk  = 1'b1;
            r.lvl = (q >= 32) ? 6'd0 : 6'(32 - q);
        end
        return r;
    endfunction

    // Result checking and expectation bookkeeping, both on the rising edge. Outputs are
    // popped before the item accepted at the same edge is pushed; with the input register
    // and the result register between them the two can never refer to the same pixel.
    always @(posedge aclk) begin : result_check
        falloff_t got_due;
        falloff_t pred;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (falloff_due.size() == 0) begin
                    report_mismatch($sformatf("result darken=%0b level=%0d with none due",
                                              m_tuser[0], m_tdata));
                end else begin
                    got_due = falloff_due.pop_front();
                    if (m_tuser[0] !== got_due.dk)
                        report_mismatch($sformatf("darken %b, expected %b",
                                                  m_tuser[0], got_due.dk));
                    if (m_tdata !== {2'b00, got_due.lvl})
                        report_mismatch($sformatf("light level %0d (0x%h), expected %0d",
                                                  m_tdata, m_tdata, got_due.lvl));
                    results_checked++;
                    if (m_tuser[0] === 1'b1)
                        darkened++;
                end
            end
            if (s_tvalid && s_tready) begin
                pred = predict_falloff(s_tuser[0], s_tdata[7:0], s_tdata[15:8]);
                falloff_due.push_back(row_typed ? row_expect : pred);
                pixels_accepted++;
                if (s_tuser[0])
                    frame_starts++;
            end
        end
    end

    // Receiver side. Each falling edge it either stalls at the current rate or, when the
    // stimulus has asked for one, holds m_tready low for a long counted stretch so that
    // both stages fill and the block has to stall its input.
    initial begin : result_sink
        int unsigned holdoff_done;
        int unsigned hold_left;
        holdoff_done = 0;
        hold_left    = 0;
        m_tready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (holdoff_done != holdoff_req) begin
                holdoff_done++;
                hold_left = HOLDOFF_LEN;
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // One APB transfer: setup cycle, then access cycle until pready, then an idle gap so
    // that back-to-back transfers never drive psel twice in the same step.
    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [7:0] wval,
                              output logic [31:0] rval);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, wval};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rval = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic check_register(input logic [1:0] idx, input logic [7:0] want);
        logic [31:0] rd;
        apb_access(1'b0, idx, 8'd0, rd);
        if (rd[7:0] !== want)
            report_mismatch($sformatf("register %0d reads 0x%h, expected 0x%h", idx, rd, want));
    endtask

    // Writes a register, keeps the mirror in step and reads the value back.
    task automatic set_register(input logic [1:0] idx, input logic [7:0] val);
        logic [31:0] rd;
        apb_access(1'b1, idx, val, rd);
        case (idx)
            REG_CENTER_X: begin
                centre_x_q = val;
            end
            REG_CENTER_Y: begin
                centre_y_q = val;
            end
            REG_BASE_RANGE: begin
                base_range_q = val;
            end
            default: begin
            end
        endcase
        check_register(idx, val);
    endtask

    // Offers one pixel, after a random idle gap, and returns on the falling edge after the
    // block has accepted it. s_tvalid stays high so that the next pixel can follow at once.
    task automatic send_pixel(input logic fs, input logic [7:0] px, input logic [7:0] py,
                              input logic typed, input falloff_t want);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= fs;
        s_tdata    <= {py, px};
        row_typed  = typed;
        row_expect = want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // The sender goes quiet until every owed result has been taken, then lets the pipeline
    // settle before anything else (such as a register write) happens.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (falloff_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // A coordinate at a random distance from the centre, reaching a little beyond the lit
    // radius so that the falloff curve is crossed from both sides. Wraps at 8 bits.
    function automatic logic [7:0] near_ring(input logic [7:0] c, input int unsigned r);
        int unsigned off;
        off = $urandom_range(r + 40);
        return $urandom_range(1) ? 8'(32'(c) + off) : 8'(32'(c) - off);
    endfunction

    // Random frames: a frame start, then small patches scanned x outer, y inner, placed
    // around the lit edge. A few frames lose their frame start, a few pixels carry a stray
    // one, and one pixel in ten is noise anywhere in the 8-bit plane.
    task automatic run_frames(input int unsigned count);
        int unsigned left;
        int unsigned frame_len;
        int unsigned w;
        int unsigned h;
        logic [7:0] x0;
        logic [7:0] y0;
        logic [7:0] px;
        logic [7:0] py;
        logic fs;
        left = count;
        while (left != 0) begin
            frame_len = $urandom_range(40, 6);
            fs = ($urandom_range(99) >= 8);
            while (frame_len != 0 && left != 0) begin
                x0 = near_ring(centre_x_q, 32'(lit_range[15:8]));
                y0 = near_ring(centre_y_q, 32'(lit_range[15:8]));
                w  = $urandom_range(6, 1);
                h  = $urandom_range(8, 1);
                for (int ix = 0; ix < w && frame_len != 0 && left != 0; ix++) begin
                    for (int iy = 0; iy < h && frame_len != 0 && left != 0; iy++) begin
                        px = 8'(32'(x0) + ix);
                        py = 8'(32'(y0) + iy);
                        if ($urandom_range(99) < 10) begin
                            px = 8'($urandom_range(255));
                            py = 8'($urandom_range(255));
                        end
                        send_pixel(fs, px, py, 1'b0, '0);
                        fs = ($urandom_range(99) < 2);
                        frame_len--;
                        left--;
                    end
                end
            end
        end
    endtask

    initial begin : stimulus
        int unsigned mode;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        // Directed rows, with the reset centre (80, 60) and a radius of 40 on entry. The
        // typed rows are at or next to the centre (always lit, whatever the dither) or at the
        // corners of the 8-bit plane (far past the edge, so fully dark). The others sit on or
        // beyond the lit edge, where the dither and the frame-start flicker decide the outcome.
        dir_rows = '{
            '{1'b0, 8'd80,  8'd60,  1'b1, '{1'b0, 6'd32}},
            '{1'b0, 8'd255, 8'd255, 1'b1, '{1'b1, 6'd0}},
            '{1'b0, 8'd0,   8'd0,   1'b1, '{1'b1, 6'd0}},
            '{1'b0, 8'd0,   8'd255, 1'b1, '{1'b1, 6'd0}},
            '{1'b0, 8'd255, 8'd0,   1'b1, '{1'b1, 6'd0}},
            '{1'b1, 8'd80,  8'd60,  1'b1, '{1'b0, 6'd32}},
            '{1'b0, 8'd81,  8'd61,  1'b1, '{1'b0, 6'd32}},
            '{1'b0, 8'd120, 8'd60,  1'b0, '{1'b0, 6'd0}},
            '{1'b0, 8'd121, 8'd60,  1'b0, '{1'b0, 6'd0}},
            '{1'b0, 8'd124, 8'd60,  1'b0, '{1'b0, 6'd0}},
            '{1'b0, 8'd130, 8'd60,  1'b0, '{1'b0, 6'd0}},
            '{1'b0, 8'd110, 8'd90,  1'b0, '{1'b0, 6'd0}},
            '{1'b1, 8'd120, 8'd60,  1'b0, '{1'b0, 6'd0}},
            '{1'b1, 8'd125, 8'd65,  1'b0, '{1'b0, 6'd0}},
            '{1'b1, 8'd80,  8'd20,  1'b0, '{1'b0, 6'd0}},
            '{1'b0, 8'd80,  8'd110, 1'b0, '{1'b0, 6'd0}},
            '{1'b0, 8'd40,  8'd60,  1'b0, '{1'b0, 6'd0}},
            '{1'b0, 8'd170, 8'd60,  1'b0, '{1'b0, 6'd0}},
            '{1'b0, 8'd85,  8'd170, 1'b0, '{1'b0, 6'd0}},
            '{1'b1, 8'd170, 8'd85,  1'b0, '{1'b0, 6'd0}},
            '{1'b0, 8'd15,  8'd240, 1'b0, '{1'b0, 6'd0}}
        };

        // Reset is held once, at the start, and released on a falling edge.
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        check_register(REG_CENTER_X, CENTER_X_RESET);
        check_register(REG_CENTER_Y, CENTER_Y_RESET);
        check_register(REG_BASE_RANGE, BASE_RANGE_RESET);

        // Directed part, with neither side idling.
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_pixel(dir_rows[i].fs, dir_rows[i].px, dir_rows[i].py,
                       dir_rows[i].typed, dir_rows[i].want);
        wait_results_done();

        // The last two settings are drawn at random; the others reach the corners of the
        // centre and both ends of the base range, including the saturating one.
        for (int p = 6; p < PHASES; p++) begin
            phase_cx[p]   = 8'($urandom_range(255));
            phase_cy[p]   = 8'($urandom_range(255));
            phase_base[p] = 8'($urandom_range(239));
        end

        // Random part. Registers change only while the pipeline is empty. The idling pattern
        // rotates through none, idle sender, stalling receiver and light idling on both; the
        // phases without idling also carry a long receiver hold-off.
        for (int p = 0; p < PHASES; p++) begin
            set_register(REG_CENTER_X, phase_cx[p]);
            set_register(REG_CENTER_Y, phase_cy[p]);
            set_register(REG_BASE_RANGE, phase_base[p]);
            mode = p % 4;
            case (mode)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                    holdoff_req    <= holdoff_req + 1;
                end
                1: begin
                    sender_idle_pct = 74;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 74;
                end
                default: begin
                    sender_idle_pct = 9;
                    recv_stall_pct  = 9;
                end
            endcase
            if (p == 2) begin
                // Halfway through, the sender pauses until every owed result is back.
                run_frames(PHASE_ITEMS / 2);
                wait_results_done();
                run_frames(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                run_frames(PHASE_ITEMS);
            end
            wait_results_done();
        end

        $display("Run covered %0d pixels with %0d frame starts; %0d results checked, %0d dark.",
                 pixels_accepted, frame_starts, results_checked, darkened);
        $display("Centres at both plane corners, base range 0 to 255 over %0d settings, %s",
                 PHASES, "with idle, stall and hold-off patterns.");
        if (mismatches == 0) begin
            $display("[radial_light_falloff_mask_core] OK");
        end else begin
            $display("[radial_light_falloff_mask_core] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
